// ===== rtl/core/smt_pkg.sv =====
package smt_pkg;

    // APB register map: register i at byte address 4*i
    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_DAMPING = 2'd0;
    localparam logic [1:0] REG_ACCEL   = 2'd1;
    localparam logic [1:0] REG_VLIMIT  = 2'd2;

    localparam logic [4:0] DAMPING_RST = 5'd9;
    localparam logic [7:0] ACCEL_RST   = 8'd1;
    localparam logic [7:0] VLIMIT_RST  = 8'd128;

    // home position: one full turn of 360 units of 256 microsteps
    localparam logic [31:0] HOME_POS = 32'd92160;

    localparam logic [9:0] PWM_MID     = 10'd512;
    localparam logic [9:0] PWM_MID_LO  = 10'd511;
    localparam logic [9:0] CLEAR_PWM_A = 10'd1020;
    localparam logic [9:0] CLEAR_PWM_B = 10'd511;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_HOME  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [31:0]        pos1;
        logic [31:0]        pos2;
        logic signed [15:0] vel;
    } t_axis_state;

    // quarter sine, 128 entries, amplitude 127
    localparam logic [6:0] SINE_ROM [128] = '{
        7'd0,   7'd1,   7'd3,   7'd4,   7'd6,   7'd7,   7'd9,   7'd10,
        7'd12,  7'd14,  7'd15,  7'd17,  7'd18,  7'd20,  7'd21,  7'd23,
        7'd24,  7'd26,  7'd28,  7'd29,  7'd31,  7'd32,  7'd34,  7'd35,
        7'd37,  7'd38,  7'd40,  7'd41,  7'd43,  7'd44,  7'd46,  7'd47,
        7'd48,  7'd50,  7'd51,  7'd53,  7'd54,  7'd56,  7'd57,  7'd58,
        7'd60,  7'd61,  7'd63,  7'd64,  7'd65,  7'd67,  7'd68,  7'd69,
        7'd71,  7'd72,  7'd73,  7'd74,  7'd76,  7'd77,  7'd78,  7'd79,
        7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd87,  7'd88,  7'd89,
        7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,  7'd96,  7'd97,
        7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105,
        7'd106, 7'd107, 7'd108, 7'd108, 7'd109, 7'd110, 7'd111, 7'd112,
        7'd112, 7'd113, 7'd114, 7'd115, 7'd115, 7'd116, 7'd117, 7'd117,
        7'd118, 7'd118, 7'd119, 7'd119, 7'd120, 7'd121, 7'd121, 7'd122,
        7'd122, 7'd122, 7'd123, 7'd123, 7'd124, 7'd124, 7'd124, 7'd125,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127,
        7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127
    };

    // first half of a low-pass stage: x*2^d - x + in, wrapping
    function automatic logic [31:0] lp_sum(input logic [31:0] x, input logic [31:0] din,
                                           input logic [4:0] d);
        return (x << d) - x + din;
    endfunction

    // second half: scale back, then +1 if below the input, else -1, floor at zero
    function automatic logic [31:0] lp_adj(input logic [31:0] sum, input logic [31:0] din,
                                           input logic [4:0] d);
        logic [31:0] t;
        t = sum >> d;
        if (t < din) begin
            return t + 32'd1;
        end else if (t != 32'd0) begin
            return t - 32'd1;
        end else begin
            return t;
        end
    endfunction

    // coil duties {a, b} from position bits 8..0
    function automatic logic [19:0] drive_pwm(input logic [8:0] pos);
        logic [6:0] idx;
        logic [9:0] s;
        logic [9:0] c;
        logic [9:0] a;
        logic [9:0] b;
        idx = pos[6:0];
        s   = {1'b0, SINE_ROM[idx], 2'b00};
        c   = {1'b0, SINE_ROM[~idx], 2'b00};
        case (pos[8:7])
            2'b11: begin
                a = PWM_MID + s;
                b = PWM_MID + c;
            end
            2'b10: begin
                a = PWM_MID - c;
                b = PWM_MID + s;
            end
            2'b01: begin
                a = PWM_MID - s;
                b = PWM_MID_LO - c;
            end
            default: begin
                a = PWM_MID + c;
                b = PWM_MID - s;
            end
        endcase
        return {a, b};
    endfunction

endpackage

// ===== rtl/core/smt_state_mem.sv =====
module smt_state_mem #(
    parameter int AXES = 4,
    parameter int AW   = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output smt_pkg::t_axis_state o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  smt_pkg::t_axis_state i_wr_data
);
    import smt_pkg::*;

    t_axis_state       r_mem [AXES];
    t_axis_state       r_rd_data;
    logic [AXES-1:0]   r_written;
    logic              r_rd_hit;

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_written[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ===== rtl/core/stepper_microstep_trajectory_unit.sv =====
// Per-axis stepper microstepping engine. Each request names an axis and an
// opcode: a step tick runs the target through two cascaded shift low-pass
// stages, limits the velocity change by accel_limit (and, where that limit
// bites, the velocity by velocity_limit), rebuilds the position and returns
// the sine/cosine coil duties for it; a clear zeroes the axis, a home sets
// both stages to 92160, and a no-op reports the axis as it stands. Axis
// state lives in one synchronous memory (one word per axis) that is read
// when a request enters and written back from stage 7 of an 8-stage
// pipeline, so requests for different axes enter one per cycle while
// o_stall is low. A request for an axis that is still in stages 1..7 is
// held by o_stall until the earlier write-back lands. An output register
// holds the result; while it is stalled the pipeline holds. Configuration
// sits on an APB port at byte addresses 0, 4 and 8.
module stepper_microstep_trajectory_unit #(
    parameter int AXES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [1:0]                  i_axis,
    input  logic [30:0]                 i_target,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [9:0]                  o_pwm_a,
    output logic [9:0]                  o_pwm_b,
    output logic [30:0]                 o_position,
    output logic signed [15:0]          o_velocity,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smt_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import smt_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic       ok;
    } t_tag;

    // configuration registers
    logic [4:0] r_damp;
    logic [7:0] r_accel;
    logic [7:0] r_vlim;

    // pipeline control
    logic [8:1] r_vld;
    t_tag       r_tag [1:8];
    logic       w_adv;
    logic       w_acc;
    logic       w_hazard;
    t_tag       n_tag;
    logic [AW+1:0] w_ax_ext;

    // memory ports
    t_axis_state w_rd;
    t_axis_state w_wr_data;
    logic        w_wr_en;

    // stage payloads
    logic [30:0]        r_s1_tgt;
    logic [31:0]        r_s2_sum, r_s2_old;
    logic [30:0]        r_s2_tgt;
    logic signed [15:0] r_s2_vold;
    logic [31:0]        r_s3_p1, r_s3_old;
    logic signed [15:0] r_s3_vold;
    logic [31:0]        r_s4_sum, r_s4_p1, r_s4_old;
    logic signed [15:0] r_s4_vold;
    logic [31:0]        r_s5_p2, r_s5_p1, r_s5_old;
    logic signed [15:0] r_s5_vold;
    logic [15:0]        r_s6_vraw;
    logic signed [17:0] r_s6_dv;
    logic [31:0]        r_s6_p1, r_s6_old;
    logic signed [15:0] r_s6_vold;
    logic signed [15:0] r_s7_v;
    logic [31:0]        r_s7_p1, r_s7_old;
    logic signed [15:0] r_s7_vold;
    logic [30:0]        r_s8_pos;
    logic signed [15:0] r_s8_vel;

    // output register
    logic               r_out_vld;
    logic [9:0]         r_pwm_a, r_pwm_b;
    logic [30:0]        r_pos;
    logic signed [15:0] r_vel;

    // combinational helpers
    logic [15:0]        n_vraw;
    logic signed [17:0] n_dv;
    logic signed [17:0] w_amax, w_vmax, w_vold, w_vraw, w_v;
    logic [31:0]        w_np;
    logic [30:0]        n_pos;
    logic signed [15:0] n_vel;
    logic [19:0]        w_pwm;

    // ---------------------------------------------------------------
    // APB: writes land on the access phase, reads return the register
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp  <= DAMPING_RST;
            r_accel <= ACCEL_RST;
            r_vlim  <= VLIMIT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DAMPING: r_damp  <= pwdata[4:0];
                REG_ACCEL:   r_accel <= pwdata[7:0];
                REG_VLIMIT:  r_vlim  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DAMPING: prdata = {27'd0, r_damp};
            REG_ACCEL:   prdata = {24'd0, r_accel};
            REG_VLIMIT:  prdata = {24'd0, r_vlim};
            default:     prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Entry: advance whole pipeline unless the result is stalled; hold
    // a request whose axis is still between read and write-back.
    // ---------------------------------------------------------------
    assign w_adv = !(r_out_vld && i_stall);

    always_comb begin
        w_hazard = 1'b0;
        for (int k = 1; k <= 7; k++) begin
            if (r_vld[k] && (r_tag[k].axis == i_axis)) begin
                w_hazard = 1'b1;
            end
        end
    end

    assign o_stall  = !w_adv || w_hazard;
    assign w_acc    = i_valid && !o_stall;
    assign w_ax_ext = (AW+2)'(i_axis);

    always_comb begin
        n_tag.op   = t_op'(i_opcode);
        n_tag.axis = i_axis;
        n_tag.ok   = (w_ax_ext < (AW+2)'(AXES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[7:1], w_acc};
            r_out_vld <= r_vld[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag[1] <= n_tag;
            for (int k = 2; k <= 8; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Axis state memory: read on entry, write back leaving stage 7
    // ---------------------------------------------------------------
    smt_state_mem #(
        .AXES (AXES),
        .AW   (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_ax_ext[AW-1:0]),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(r_tag[7].axis)),
        .i_wr_data (w_wr_data)
    );

    // ---------------------------------------------------------------
    // Stages 1..8: filter stages, raw velocity and the later stage registers
    // ---------------------------------------------------------------
    assign n_vraw = r_s5_p2[15:0] - r_s5_old[15:0];
    assign n_dv   = {{2{n_vraw[15]}}, n_vraw} - {{2{r_s5_vold[15]}}, r_s5_vold};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 1: hold the target while the memory read completes
            r_s1_tgt  <= i_target;
            // stage 2: first stage sum
            r_s2_sum  <= lp_sum(w_rd.pos1, {1'b0, r_s1_tgt}, r_damp);
            r_s2_tgt  <= r_s1_tgt;
            r_s2_old  <= w_rd.pos2;
            r_s2_vold <= w_rd.vel;
            // stage 3: first stage output
            r_s3_p1   <= lp_adj(r_s2_sum, {1'b0, r_s2_tgt}, r_damp);
            r_s3_old  <= r_s2_old;
            r_s3_vold <= r_s2_vold;
            // stage 4: second stage sum
            r_s4_sum  <= lp_sum(r_s3_old, r_s3_p1, r_damp);
            r_s4_p1   <= r_s3_p1;
            r_s4_old  <= r_s3_old;
            r_s4_vold <= r_s3_vold;
            // stage 5: second stage output
            r_s5_p2   <= lp_adj(r_s4_sum, r_s4_p1, r_damp);
            r_s5_p1   <= r_s4_p1;
            r_s5_old  <= r_s4_old;
            r_s5_vold <= r_s4_vold;
            // stage 6: raw velocity and its change
            r_s6_vraw <= n_vraw;
            r_s6_dv   <= n_dv;
            r_s6_p1   <= r_s5_p1;
            r_s6_old  <= r_s5_old;
            r_s6_vold <= r_s5_vold;
            // stage 7: limited velocity
            r_s7_v    <= w_v[15:0];
            r_s7_p1   <= r_s6_p1;
            r_s7_old  <= r_s6_old;
            r_s7_vold <= r_s6_vold;
            // stage 8: result fields
            r_s8_pos  <= n_pos;
            r_s8_vel  <= n_vel;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6 -> 7: acceleration limit, then velocity clamp
    // ---------------------------------------------------------------
    always_comb begin
        w_amax = {10'd0, r_accel};
        w_vmax = {10'd0, r_vlim};
        w_vold = {{2{r_s6_vold[15]}}, r_s6_vold};
        w_vraw = {{2{r_s6_vraw[15]}}, r_s6_vraw};
        w_v    = w_vraw;
        if (r_s6_dv > 18'sd0) begin
            if (r_s6_dv > w_amax) begin
                w_v = w_vold + w_amax;
                if (w_v > w_vmax) begin
                    w_v = w_vmax;
                end
            end
        end else if (r_s6_dv < -w_amax) begin
            w_v = w_vold - w_amax;
            if (w_v < -w_vmax) begin
                w_v = -w_vmax;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 7 -> 8: rebuild position, write back, pick result fields
    // ---------------------------------------------------------------
    always_comb begin
        w_np = r_s7_old + {{16{r_s7_v[15]}}, r_s7_v};
        if (w_np[31]) begin
            w_np = 32'd0;
        end

        w_wr_data = '0;
        w_wr_en   = 1'b0;
        n_pos     = 31'd0;
        n_vel     = 16'sd0;
        case (r_tag[7].op)
            OP_STEP: begin
                w_wr_data.pos1 = r_s7_p1;
                w_wr_data.pos2 = w_np;
                w_wr_data.vel  = r_s7_v;
                w_wr_en        = 1'b1;
                n_pos          = w_np[30:0];
                n_vel          = r_s7_v;
            end
            OP_CLEAR: begin
                w_wr_en = 1'b1;
            end
            OP_HOME: begin
                w_wr_data.pos1 = HOME_POS;
                w_wr_data.pos2 = HOME_POS;
                w_wr_data.vel  = r_s7_vold;
                w_wr_en        = 1'b1;
                n_pos          = HOME_POS[30:0];
                n_vel          = r_s7_vold;
            end
            default: begin
                n_pos = r_s7_old[30:0];
                n_vel = r_s7_vold;
            end
        endcase

        // drop writes of bubbles, stalled cycles and axes beyond the range
        if (!(w_adv && r_vld[7] && r_tag[7].ok)) begin
            w_wr_en = 1'b0;
        end
        if (!r_tag[7].ok) begin
            n_pos = 31'd0;
            n_vel = 16'sd0;
        end
    end

    // ---------------------------------------------------------------
    // Stage 8 -> output register: coil duties from the sine table, fixed ones for a clear
    // ---------------------------------------------------------------
    assign w_pwm = drive_pwm(r_s8_pos[8:0]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos <= r_s8_pos;
            r_vel <= r_s8_vel;
            if (!r_tag[8].ok) begin
                r_pwm_a <= 10'd0;
                r_pwm_b <= 10'd0;
            end else if (r_tag[8].op == OP_CLEAR) begin
                r_pwm_a <= CLEAR_PWM_A;
                r_pwm_b <= CLEAR_PWM_B;
            end else begin
                r_pwm_a <= w_pwm[19:10];
                r_pwm_b <= w_pwm[9:0];
            end
        end
    end

    assign o_valid    = r_out_vld;
    assign o_pwm_a    = r_pwm_a;
    assign o_pwm_b    = r_pwm_b;
    assign o_position = r_pos;
    assign o_velocity = r_vel;

endmodule

// ===== rtl/core/smt_checker.sv =====
module smt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic [1:0]                  i_axis,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [9:0]                  o_pwm_a,
    input  logic [9:0]                  o_pwm_b,
    input  logic [30:0]                 o_position,
    input  logic signed [15:0]          o_velocity,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smt_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata
);
    import smt_pkg::*;

    // a held result keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pwm_a) && $stable(o_pwm_b)
            && $stable(o_position) && $stable(o_velocity))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds the whole pipeline, so no request enters
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("request taken while result stalled");

    // a same-axis request straight behind an accepted one is held
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 (i_valid && i_axis == $past(i_axis)) |-> o_stall)
        else $error("same-axis request taken before write-back");

    // a written damping shift reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[3:2] == REG_DAMPING
        |=> paddr[3:2] != REG_DAMPING || prdata == {27'd0, $past(pwdata[4:0])})
        else $error("damping shift readback mismatch");

endmodule

bind stepper_microstep_trajectory_unit smt_checker u_smt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_axis     (i_axis),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_pwm_a    (o_pwm_a),
    .o_pwm_b    (o_pwm_b),
    .o_position (o_position),
    .o_velocity (o_velocity),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

// ===== tb/sv/stepper_microstep_trajectory_unit_tb.sv =====
module stepper_microstep_trajectory_unit_tb;

    import smt_pkg::*;

    // depth of the block's pipeline, used for the settle time after the last result
    localparam int PIPE_LAT = 8;
    // one past the last register: writes there must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 210;

    typedef struct packed {
        logic [9:0]  pwm_a;
        logic [9:0]  pwm_b;
        logic [30:0] position;
        logic [15:0] velocity;
    } coil_result_t;

    typedef struct packed {
        t_op          op;
        logic [1:0]   ax;
        logic [30:0]  tgt;
        logic         has_fixed;
        coil_result_t fixed_res;
    } drive_row_t;

    typedef struct packed {
        logic [4:0] damp;
        logic [7:0] accel;
        logic [7:0] vlim;
    } tuning_t;

    // results that can be read straight off the opcode
    localparam coil_result_t AT_ZERO = '{10'd1020, 10'd512, 31'd0, 16'd0};
    localparam coil_result_t AT_HOME = '{10'd1020, 10'd512, 31'd92160, 16'd0};
    localparam coil_result_t CLEARED = '{10'd1020, 10'd511, 31'd0, 16'd0};
    localparam coil_result_t NO_FIX  = '0;

    // directed requests, run under the reset settings (damping 9, accel 1, vlimit 128)
    localparam drive_row_t DIRECTED [21] = '{
        '{OP_NONE,  2'd0, 31'd0,           1'b1, AT_ZERO},  // report of a fresh axis
        '{OP_STEP,  2'd0, 31'd0,           1'b1, AT_ZERO},  // step at rest, no nudge below 0
        '{OP_HOME,  2'd1, 31'd0,           1'b1, AT_HOME},
        '{OP_CLEAR, 2'd1, 31'h7FFF_FFFF,   1'b1, CLEARED},  // clear ignores the target
        '{OP_STEP,  2'd2, 31'h7FFF_FFFF,   1'b0, NO_FIX},   // largest target
        '{OP_STEP,  2'd2, 31'h7FFF_FFFF,   1'b0, NO_FIX},
        '{OP_STEP,  2'd3, 31'h7FFF_FFFF,   1'b0, NO_FIX},
        '{OP_STEP,  2'd3, 31'h2AAA_AAAA,   1'b0, NO_FIX},
        '{OP_STEP,  2'd0, 31'h5555_5555,   1'b0, NO_FIX},
        '{OP_HOME,  2'd2, 31'd0,           1'b0, NO_FIX},   // home keeps the velocity
        '{OP_STEP,  2'd2, 31'd0,           1'b0, NO_FIX},   // move down from home
        '{OP_STEP,  2'd2, 31'd0,           1'b0, NO_FIX},
        '{OP_NONE,  2'd2, 31'h7FFF_FFFF,   1'b0, NO_FIX},
        '{OP_CLEAR, 2'd3, 31'd0,           1'b1, CLEARED},
        '{OP_NONE,  2'd3, 31'd0,           1'b1, AT_ZERO},
        '{OP_HOME,  2'd3, 31'd92160,       1'b1, AT_HOME},
        '{OP_STEP,  2'd3, 31'd92160,       1'b0, NO_FIX},   // target equal to position
        '{OP_STEP,  2'd1, 31'd92416,       1'b0, NO_FIX},
        '{OP_STEP,  2'd1, 31'd92416,       1'b0, NO_FIX},
        '{OP_CLEAR, 2'd0, 31'd12345,       1'b1, CLEARED},
        '{OP_STEP,  2'd0, 31'h7FFF_FFFF,   1'b0, NO_FIX}
    };

    // fixed settings for the first random phases: both extremes, then mid values
    localparam tuning_t TUNING_PLAN [6] = '{
        '{5'd0,  8'd0,   8'd0},
        '{5'd31, 8'd255, 8'd255},
        '{5'd0,  8'd255, 8'd255},
        '{5'd1,  8'd255, 8'd128},
        '{5'd9,  8'd1,   8'd128},
        '{5'd3,  8'd8,   8'd32}
    };

    // quarter sine, amplitude 127
    localparam logic [6:0] QSINE [128] = '{
        7'd0,   7'd1,   7'd3,   7'd4,   7'd6,   7'd7,   7'd9,   7'd10,
        7'd12,  7'd14,  7'd15,  7'd17,  7'd18,  7'd20,  7'd21,  7'd23,
        7'd24,  7'd26,  7'd28,  7'd29,  7'd31,  7'd32,  7'd34,  7'd35,
        7'd37,  7'd38,  7'd40,  7'd41,  7'd43,  7'd44,  7'd46,  7'd47,
        7'd48,  7'd50,  7'd51,  7'd53,  7'd54,  7'd56,  7'd57,  7'd58,
        7'd60,  7'd61,  7'd63,  7'd64,  7'd65,  7'd67,  7'd68,  7'd69,
        7'd71,  7'd72,  7'd73,  7'd74,  7'd76,  7'd77,  7'd78,  7'd79,
        7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd87,  7'd88,  7'd89,
        7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,  7'd96,  7'd97,
        7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105,
        7'd106, 7'd107, 7'd108, 7'd108, 7'd109, 7'd110, 7'd111, 7'd112,
        7'd112, 7'd113, 7'd114, 7'd115, 7'd115, 7'd116, 7'd117, 7'd117,
        7'd118, 7'd118, 7'd119, 7'd119, 7'd120, 7'd121, 7'd121, 7'd122,
        7'd122, 7'd122, 7'd123, 7'd123, 7'd124, 7'd124, 7'd124, 7'd125,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127,
        7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127
    };

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               o_stall;
    logic [1:0]         i_opcode  = 2'd0;
    logic [1:0]         i_axis    = 2'd0;
    logic [30:0]        i_target  = 31'd0;
    logic               o_valid;
    logic               i_stall   = 1'b0;
    logic [9:0]         o_pwm_a;
    logic [9:0]         o_pwm_b;
    logic [30:0]        o_position;
    logic signed [15:0] o_velocity;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [CFG_AW-1:0]  paddr     = '0;
    logic [31:0]        pwdata    = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    // predicted axis state and settings, tracked at request acceptance
    logic [31:0]        track_pos1 [4] = '{default: '0};
    logic [31:0]        track_pos2 [4] = '{default: '0};
    logic signed [15:0] track_vel  [4] = '{default: '0};
    logic [4:0]         cur_damp  = 5'd9;
    logic [7:0]         cur_accel = 8'd1;
    logic [7:0]         cur_vlim  = 8'd128;

    coil_result_t expected_coil [$];

    int  mismatches = 0;
    int  n_requests = 0;
    int  n_results  = 0;
    int  n_settings = 0;
    int  rx_hold    = 0;
    bit  calm_tx    = 1'b0;
    bit  calm_rx    = 1'b0;

    stepper_microstep_trajectory_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_opcode   (i_opcode),
        .i_axis     (i_axis),
        .i_target   (i_target),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pwm_a    (o_pwm_a),
        .o_pwm_b    (o_pwm_b),
        .o_position (o_position),
        .o_velocity (o_velocity),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends here
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // one shift low-pass stage: scale, then +1 if below the input, else -1, floor at 0
    function automatic logic [31:0] lowpass(input logic [31:0] x, input logic [31:0] din,
                                            input logic [4:0] d);
        logic [31:0] y;
        y = ((x << d) - x + din) >> d;
        if (y < din) y = y + 32'd1;
        else if (y != 32'd0) y = y - 32'd1;
        return y;
    endfunction

    // advance the tracked axis state by one request and form its result
    function automatic coil_result_t predict_motion(input t_op op, input logic [1:0] ax,
                                                    input logic [30:0] tgt);
        logic [31:0]        p1;
        logic [31:0]        p2;
        logic [31:0]        old;
        logic [31:0]        np;
        logic signed [15:0] diff;
        logic [6:0]         idx;
        logic [9:0]         s;
        logic [9:0]         c;
        logic [8:0]         phase;
        int                 v;
        int                 vold;
        int                 dv;
        int                 amax;
        int                 vmax;
        coil_result_t       r;

        case (op)
            OP_CLEAR: begin
                track_pos1[ax] = '0;
                track_pos2[ax] = '0;
                track_vel[ax]  = '0;
                return CLEARED;
            end
            OP_HOME: begin
                track_pos1[ax] = HOME_POS;
                track_pos2[ax] = HOME_POS;
            end
            OP_STEP: begin
                old  = track_pos2[ax];
                vold = track_vel[ax];
                amax = cur_accel;
                vmax = cur_vlim;
                p1   = lowpass(track_pos1[ax], {1'b0, tgt}, cur_damp);
                p2   = lowpass(old, p1, cur_damp);
                diff = p2[15:0] - old[15:0];
                v    = diff;
                dv   = v - vold;
                // clamp to vlimit only when the acceleration limit bites
                if (dv > 0) begin
                    if (dv > amax) begin
                        v = vold + amax;
                        if (v > vmax) v = vmax;
                    end
                end else if (dv < -amax) begin
                    v = vold - amax;
                    if (v < -vmax) v = -vmax;
                end
                np = old + 32'(v);
                if (np[31]) np = '0;
                track_pos1[ax] = p1;
                track_pos2[ax] = np;
                track_vel[ax]  = 16'(v);
            end
            default: begin
                // no-op: report the axis as it stands
            end
        endcase

        phase = track_pos2[ax][8:0];
        idx   = phase[6:0];
        s     = {1'b0, QSINE[idx], 2'b00};
        c     = {1'b0, QSINE[7'd127 - idx], 2'b00};
        case (phase[8:7])
            2'b11: begin
                r.pwm_a = 10'd512 + s;
                r.pwm_b = 10'd512 + c;
            end
            2'b10: begin
                r.pwm_a = 10'd512 - c;
                r.pwm_b = 10'd512 + s;
            end
            2'b01: begin
                r.pwm_a = 10'd512 - s;
                r.pwm_b = 10'd511 - c;
            end
            default: begin
                r.pwm_a = 10'd512 + c;
                r.pwm_b = 10'd512 - s;
            end
        endcase
        r.position = track_pos2[ax][30:0];
        r.velocity = track_vel[ax];
        return r;
    endfunction

    // offer one request after a random gap, hold it until taken, then log its result
    task automatic send_request(input t_op op, input logic [1:0] ax, input logic [30:0] tgt,
                                input logic has_fixed, input coil_result_t fixed_res);
        int           gap;
        coil_result_t forecast;
        gap = calm_tx ? 0 : idle_span();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_axis   <= ax;
        i_target <= tgt;
        do @(posedge i_clk); while (o_stall);
        forecast = predict_motion(op, ax, tgt);
        expected_coil.push_back(has_fixed ? fixed_res : forecast);
        n_requests++;
    endtask

    // drop valid, let every pending result drain and the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_coil.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // write the registers and unused slot with junk above each field, read real ones back
    task automatic set_config(input tuning_t t);
        logic [31:0] want [4];
        logic [31:0] mask [4];
        int          idx;
        want[REG_DAMPING] = {27'd0, t.damp};
        want[REG_ACCEL]   = {24'd0, t.accel};
        want[REG_VLIMIT]  = {24'd0, t.vlim};
        want[REG_UNUSED]  = 32'd0;
        mask[REG_DAMPING] = 32'h1F;
        mask[REG_ACCEL]   = 32'hFF;
        mask[REG_VLIMIT]  = 32'hFF;
        mask[REG_UNUSED]  = 32'h0;
        for (idx = 0; idx < 4; idx++) begin
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= CFG_AW'(4 * idx);
            pwdata  <= (want[idx] & mask[idx]) | ($urandom & ~mask[idx]);
            @(negedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            if (idx < REG_UNUSED) begin
                @(negedge i_clk);
                psel   <= 1'b1;
                pwrite <= 1'b0;
                @(negedge i_clk);
                penable <= 1'b1;
                @(posedge i_clk);
                if (prdata !== want[idx])
                    note_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                                            idx, want[idx], prdata));
                @(negedge i_clk);
                psel    <= 1'b0;
                penable <= 1'b0;
            end
        end
        cur_damp  = t.damp;
        cur_accel = t.accel;
        cur_vlim  = t.vlim;
        n_settings++;
    endtask

    // result side: random stall runs, with calm stretches
    always @(negedge i_clk) begin
        if (rx_hold == 0 && !calm_rx && $urandom_range(0, 3) == 0) rx_hold = idle_span();
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        coil_result_t got;
        coil_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            got = '{o_pwm_a, o_pwm_b, o_position, o_velocity};
            if (expected_coil.size() == 0) begin
                note_mismatch($sformatf("unexpected result a=%0d b=%0d pos=%0d vel=%0d",
                                        got.pwm_a, got.pwm_b, got.position,
                                        $signed(got.velocity)));
            end else begin
                want = expected_coil.pop_front();
                if (got !== want)
                    note_mismatch($sformatf({"result %0d: expected a=%0d b=%0d pos=%0d ",
                                             "vel=%0d, got a=%0d b=%0d pos=%0d vel=%0d"},
                                            n_results, want.pwm_a, want.pwm_b,
                                            want.position, $signed(want.velocity),
                                            got.pwm_a, got.pwm_b, got.position,
                                            $signed(got.velocity)));
            end
        end
    end

    initial begin : stimulus
        int          k;
        int          ph;
        int          n;
        int          pick;
        t_op         op;
        logic [1:0]  ax;
        logic [30:0] tgt;
        longint      aim;
        longint      span;
        tuning_t     t;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < $size(DIRECTED); k++)
            send_request(DIRECTED[k].op, DIRECTED[k].ax, DIRECTED[k].tgt,
                         DIRECTED[k].has_fixed, DIRECTED[k].fixed_res);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph < $size(TUNING_PLAN)) begin
                t = TUNING_PLAN[ph];
            end else begin
                t.damp  = 5'($urandom_range(0, 12));
                t.accel = 8'($urandom_range(0, 255));
                t.vlim  = 8'($urandom_range(0, 255));
            end
            set_config(t);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // switch idling on or off for each side every so often
                if (n % 60 == 0) begin
                    calm_tx = ($urandom_range(0, 3) == 0);
                    calm_rx = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 72) op = OP_STEP;
                else if (pick < 80) op = OP_CLEAR;
                else if (pick < 88) op = OP_HOME;
                else op = OP_NONE;
                ax = 2'($urandom_range(0, 3));

                // mostly targets near the tracked position so the filter and limits engage
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    span = longint'(1) << $urandom_range(2, 18);
                    aim  = longint'(track_pos2[ax]) + longint'($urandom_range(0, 2 * span))
                           - span;
                end else if (pick < 8) begin
                    aim = longint'($urandom & 32'h7FFF_FFFF);
                end else if (pick == 8) begin
                    aim = $urandom_range(0, 1) ? 64'h7FFF_FFFF : 64'd0;
                end else begin
                    aim = longint'(HOME_POS) + longint'($urandom_range(0, 1024)) - 512;
                end
                if (aim < 0) aim = 0;
                if (aim > 64'h7FFF_FFFF) aim = 64'h7FFF_FFFF;
                tgt = aim[30:0];
                send_request(op, ax, tgt, 1'b0, NO_FIX);
            end
        end

        drain();
        $display("covered %0d requests, %0d results, %0d register settings",
                 n_requests, n_results, n_settings);
        $display("settings spanned damping 0..31 and both limits 0..255");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
